// ----- rtl/fhp_pkg.sv -----
// Shared types, constants and lookup tables for the frame header parser.
// No dependencies; imported by every module of the block.
package fhp_pkg;

    // byte positions of the header walk
    localparam logic [3:0] POS_SYNC0 = 4'd0;
    localparam logic [3:0] POS_SYNC1 = 4'd1;
    localparam logic [3:0] POS_BYTE2 = 4'd2;
    localparam logic [3:0] POS_BYTE3 = 4'd3;
    localparam logic [3:0] POS_LEAD  = 4'd4;
    localparam logic [3:0] POS_LAST  = 4'd12;
    localparam logic [3:0] POS_IDLE  = 4'd15;

    // longest coded number accepted, in bytes (1 to 7)
    localparam logic [2:0] MAX_NUMBER_BYTES = 3'd7;

    // sync pattern pieces
    localparam logic [7:0] SYNC_BYTE = 8'hFF;
    localparam logic [5:0] SYNC_TAIL = 6'h3E;

    // block size codes that take extension bytes
    localparam logic [3:0] BS_EXT8  = 4'd6;
    localparam logic [3:0] BS_EXT16 = 4'd7;

    // header length limits
    localparam logic [3:0] HDR_LEN_MIN = 4'd5;
    localparam logic [3:0] HDR_LEN_MAX = 4'd13;

    localparam int ResultWidth = 89;
    localparam int OutDataWidth = 96;

    // fixed fields gathered from header bytes 0 to 3
    typedef struct packed {
        logic       number_invalid;
        logic       sync_ok;
        logic       variable_blocking;
        logic       reserved_a;
        logic [7:0] byte2;
        logic [7:0] byte3;
    } fix_t;

    // one parsed header, sync_match in the lowest bits, header_length in the highest
    typedef struct packed {
        logic [3:0]  header_length;
        logic        number_invalid;
        logic [35:0] frame_number;
        logic        reserved_b;
        logic [4:0]  sample_bits;
        logic [3:0]  channel_mode;
        logic [17:0] rate_hz;
        logic [16:0] block_samples;
        logic        variable_blocking;
        logic        reserved_a;
        logic        sync_match;
    } res_t;

    // sample rate table
    function automatic logic [17:0] rate_lookup(input logic [3:0] code);
        logic [17:0] r;
        begin
            unique case (code)
                4'd1:    r = 18'd88200;
                4'd2:    r = 18'd176400;
                4'd3:    r = 18'd192000;
                4'd4:    r = 18'd8000;
                4'd5:    r = 18'd16000;
                4'd6:    r = 18'd22050;
                4'd7:    r = 18'd24000;
                4'd8:    r = 18'd32000;
                4'd9:    r = 18'd44100;
                4'd10:   r = 18'd48000;
                4'd11:   r = 18'd96000;
                default: r = 18'd0;
            endcase
            return r;
        end
    endfunction

    // block size table for the codes without extension bytes
    function automatic logic [16:0] size_lookup(input logic [3:0] code);
        logic [16:0] s;
        begin
            unique case (code)
                4'd1:    s = 17'd192;
                4'd2:    s = 17'd576;
                4'd3:    s = 17'd1152;
                4'd4:    s = 17'd2304;
                4'd5:    s = 17'd4608;
                4'd8:    s = 17'd256;
                4'd9:    s = 17'd512;
                4'd10:   s = 17'd1024;
                4'd11:   s = 17'd2048;
                4'd12:   s = 17'd4096;
                4'd13:   s = 17'd8192;
                4'd14:   s = 17'd16384;
                4'd15:   s = 17'd32768;
                default: s = 17'd0;
            endcase
            return s;
        end
    endfunction

    // bits per sample table
    function automatic logic [4:0] bits_lookup(input logic [2:0] code);
        logic [4:0] b;
        begin
            unique case (code)
                3'd1:    b = 5'd8;
                3'd2:    b = 5'd12;
                3'd4:    b = 5'd16;
                3'd5:    b = 5'd20;
                3'd6:    b = 5'd24;
                default: b = 5'd0;
            endcase
            return b;
        end
    endfunction

    // total coded number length from the lead byte, 0 when not a lead byte
    function automatic logic [2:0] lead_count(input logic [7:0] b);
        logic [2:0] n;
        begin
            if (b[7] == 1'b0)
                n = 3'd1;
            else if (b[7:5] == 3'b110)
                n = 3'd2;
            else if (b[7:4] == 4'b1110)
                n = 3'd3;
            else if (b[7:3] == 5'b11110)
                n = 3'd4;
            else if (b[7:2] == 6'b111110)
                n = 3'd5;
            else if (b[7:1] == 7'b1111110)
                n = 3'd6;
            else if (b == 8'hFE)
                n = 3'd7;
            else
                n = 3'd0;
            return n;
        end
    endfunction

endpackage

// ----- rtl/flac_frame_header_parser.sv -----
// Audio frame header parser, one header byte per beat, one result per header.
// The input byte is registered, walked combinationally and the result registered in fhp_out_buf.
// Throughput: one byte per cycle while the skid of the result buffer is empty.
// Reset (rst_n, asynchronous, active low) clears the valid flags and walk state and arms the
// walk so the next byte is taken as header byte 0.
// Depends on fhp_pkg, fhp_parse and fhp_out_buf.
module flac_frame_header_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // header_byte[7:0]
    input  logic        s_tuser,   // first_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // sync_match, reserved_a, variable_blocking, block_samples[16:0], rate_hz[17:0],
    // channel_mode[3:0], sample_bits[4:0], reserved_b, frame_number[35:0],
    // number_invalid, header_length[3:0], zero fill
    output logic [95:0] m_tdata
);
    import fhp_pkg::*;

    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       first_reg;
    logic       buf_ready;
    logic       step;
    logic       res_valid;
    res_t       res;
    res_t       out_data;

    assign step     = in_valid_reg && buf_ready;
    assign s_tready = !in_valid_reg || buf_ready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            byte_reg  <= s_tdata;
            first_reg <= s_tuser;
        end
    end

    // header walk
    fhp_parse u_parse
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .header_byte (byte_reg),
        .first_byte  (first_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    // result register and skid
    fhp_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_valid  (res_valid),
        .wr_data   (res),
        .wr_ready  (buf_ready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {(OutDataWidth - ResultWidth)'(0), out_data};

endmodule

// ----- rtl/fhp_parse.sv -----
// Header walk: position counter, gathered fields and number accumulators.
// Depends on fhp_pkg; produces one result on the byte that ends a header.
module fhp_parse
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic [7:0]    header_byte,
    input  logic          first_byte,
    output logic          res_valid,
    output fhp_pkg::res_t res
);
    import fhp_pkg::*;

    logic [3:0]  pos_reg, pos_next;
    fix_t        fix_reg, fix_next;
    logic [35:0] num_reg, num_next;
    logic [2:0]  num_left_reg, num_left_next;
    logic [15:0] ext_reg, ext_next;
    logic [1:0]  ext_left_reg, ext_left_next;

    logic [3:0]  pos_cur;
    logic [2:0]  lead_n;
    logic [7:0]  lead_mask;
    logic        num_done;
    logic        emit;
    logic [3:0]  bs_code;
    logic [16:0] bsz;

    assign pos_cur   = first_byte ? POS_SYNC0 : pos_reg;
    assign lead_n    = lead_count(header_byte);
    assign lead_mask = 8'hFF >> ({1'b0, lead_n} + 4'd1);
    assign bs_code   = fix_reg.byte2[7:4];

    // next state of the walk for the byte on the input
    always_comb
    begin
        pos_next      = pos_cur;
        fix_next      = fix_reg;
        num_next      = num_reg;
        num_left_next = num_left_reg;
        ext_next      = ext_reg;
        ext_left_next = ext_left_reg;
        num_done      = 1'b0;
        emit          = 1'b0;
        if (pos_cur == POS_SYNC0)
        begin
            fix_next         = '0;
            fix_next.sync_ok = (header_byte == SYNC_BYTE);
            pos_next         = POS_SYNC1;
        end
        else if (pos_cur == POS_SYNC1)
        begin
            fix_next.sync_ok           = fix_reg.sync_ok && (header_byte[7:2] == SYNC_TAIL);
            fix_next.variable_blocking = header_byte[1];
            fix_next.reserved_a        = header_byte[0];
            pos_next                   = POS_BYTE2;
        end
        else if (pos_cur == POS_BYTE2)
        begin
            fix_next.byte2 = header_byte;
            pos_next       = POS_BYTE3;
        end
        else if (pos_cur == POS_BYTE3)
        begin
            fix_next.byte3 = header_byte;
            pos_next       = POS_LEAD;
        end
        else if (pos_cur == POS_LEAD)
        begin
            if (lead_n == 3'd0 || lead_n > MAX_NUMBER_BYTES)
            begin
                fix_next.number_invalid = 1'b1;
                num_next                = '0;
                num_left_next           = '0;
                num_done                = 1'b1;
            end
            else
            begin
                num_next      = {28'd0, (lead_n == 3'd1) ? header_byte
                                                         : (header_byte & lead_mask)};
                num_left_next = lead_n - 3'd1;
                num_done      = (lead_n == 3'd1);
                pos_next      = POS_LEAD + 4'd1;
            end
        end
        else if (pos_cur != POS_IDLE && pos_cur <= POS_LAST)
        begin
            if (num_left_reg != 3'd0)
            begin
                num_next      = {num_reg[29:0], header_byte[5:0]};
                num_left_next = num_left_reg - 3'd1;
                num_done      = (num_left_reg == 3'd1);
                pos_next      = pos_cur + 4'd1;
            end
            else if (ext_left_reg != 2'd0)
            begin
                ext_next      = {ext_reg[7:0], header_byte};
                ext_left_next = ext_left_reg - 2'd1;
                emit          = (ext_left_reg == 2'd1);
                pos_next      = pos_cur + 4'd1;
            end
            else
            begin
                pos_next = POS_IDLE;
            end
        end
        else
        begin
            pos_next = POS_IDLE;
        end

        // number complete: set up extension bytes or finish
        if (num_done)
        begin
            ext_next = '0;
            if (bs_code == BS_EXT8)
                ext_left_next = 2'd1;
            else if (bs_code == BS_EXT16)
                ext_left_next = 2'd2;
            else
                ext_left_next = 2'd0;
            emit     = (bs_code != BS_EXT8) && (bs_code != BS_EXT16);
            pos_next = pos_cur + 4'd1;
        end
        if (emit)
            pos_next = POS_IDLE;
    end

    // block size from table or extension value plus one
    always_comb
    begin
        if (bs_code == BS_EXT8)
            bsz = {9'd0, ext_next[7:0]} + 17'd1;
        else if (bs_code == BS_EXT16)
            bsz = {1'b0, ext_next} + 17'd1;
        else
            bsz = size_lookup(bs_code);
    end

    // result fields
    assign res_valid = step && emit;
    always_comb
    begin
        res.sync_match        = fix_next.sync_ok;
        res.reserved_a        = fix_next.reserved_a;
        res.variable_blocking = fix_next.variable_blocking;
        res.block_samples     = bsz;
        res.rate_hz           = rate_lookup(fix_next.byte2[3:0]);
        res.channel_mode      = fix_next.byte3[7:4];
        res.sample_bits       = bits_lookup(fix_next.byte3[3:1]);
        res.reserved_b        = fix_next.byte3[0];
        res.frame_number      = fix_next.number_invalid ? 36'd0 : num_next;
        res.number_invalid    = fix_next.number_invalid;
        res.header_length     = pos_cur + 4'd1;
    end

    // walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= POS_SYNC0;
            fix_reg      <= '0;
            num_reg      <= '0;
            num_left_reg <= '0;
            ext_reg      <= '0;
            ext_left_reg <= '0;
        end
        else if (step)
        begin
            pos_reg      <= pos_next;
            fix_reg      <= fix_next;
            num_reg      <= num_next;
            num_left_reg <= num_left_next;
            ext_reg      <= ext_next;
            ext_left_reg <= ext_left_next;
        end
    end

`ifndef NO_ASSERTIONS
    // position only ever holds a header byte index or idle
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LAST || pos_reg == POS_IDLE)
        else $error("header position out of range");

    // a finished header reports a plausible length
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.header_length >= HDR_LEN_MIN && res.header_length <= HDR_LEN_MAX))
        else $error("header length out of range");

    // the walk goes idle after a result
    a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> pos_reg == POS_IDLE)
        else $error("parser not idle after result");
`endif

endmodule

// ----- rtl/fhp_out_buf.sv -----
// Result register with a skid stage behind it for the master-side stream.
// Depends on fhp_pkg for the result type.
module fhp_out_buf
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    input  fhp_pkg::res_t wr_data,
    output logic          wr_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output fhp_pkg::res_t out_data
);
    import fhp_pkg::*;

    logic out_valid_reg;
    res_t out_data_reg;
    logic skid_valid_reg;
    res_t skid_data_reg;
    logic out_free;

    assign wr_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || wr_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (wr_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : wr_data;
        end
        else if (wr_valid)
        begin
            skid_data_reg <= wr_data;
        end
    end

`ifndef NO_ASSERTIONS
    // skid only fills behind a held result
    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds data while output empty");

    // no write while the skid is full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_valid && skid_valid_reg))
        else $error("result buffer overflow");

    // a stalled result with a new write lands in the skid
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready && wr_valid) |=> skid_valid_reg)
        else $error("result lost on stall");
`endif

endmodule
